FILE: hdl/rlmf_pkg.sv
`timescale 1ns / 1ps

package rlmf_pkg;

   localparam int CAPACITY_DEF     = 32;
   localparam int PAYLOAD_BITS_DEF = 32;

   localparam int OP_W     = 3;
   localparam int KEY_HI_W = 24;
   localparam int KEY_LO_W = 64;
   localparam int PL_W     = 32;
   localparam int POS_W    = 6;
   localparam int STAT_W   = 3;
   localparam int TOTAL_W  = 7;

   localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 3'd2;
   localparam logic [OP_W-1:0] OP_APPEND = 3'd3;
   localparam logic [OP_W-1:0] OP_READ   = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

   localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd1;
   localparam logic [STAT_W-1:0] STAT_DUPLICATE = 3'd2;
   localparam logic [STAT_W-1:0] STAT_FULL      = 3'd3;
   localparam logic [STAT_W-1:0] STAT_BAD_INDEX = 3'd4;

   typedef struct packed {
      logic [KEY_HI_W-1:0] key_high;
      logic [KEY_LO_W-1:0] key_low;
      logic [PL_W-1:0]     payload;
   } entry_type;

   typedef struct packed {
      logic             capture;
      logic             use_key;
      logic             use_index;
      logic             apply;
      logic             up;
      logic             dn;
      logic             put;
      logic [POS_W-1:0] count;
      logic [POS_W-1:0] index;
      logic [POS_W-1:0] lo;
      logic [POS_W-1:0] hi;
      logic [POS_W-1:0] put_at;
   } cell_ctl_type;

endpackage

FILE: hdl/rlmf_cell.sv
`timescale 1ns / 1ps

module rlmf_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rlmf_pkg::cell_ctl_type ctl,
   input  rlmf_pkg::entry_type   new_entry,
   input  rlmf_pkg::entry_type   left_entry,
   input  rlmf_pkg::entry_type   right_entry,
   output rlmf_pkg::entry_type   entry,
   output logic                  sel
);

   localparam logic [rlmf_pkg::POS_W-1:0] HERE = rlmf_pkg::POS_W'(CELL_INDEX);

   rlmf_pkg::entry_type entry_ff, entry_in;
   logic                sel_ff, sel_in;
   logic                valid;
   logic                match;

   always_comb begin
      valid = HERE < ctl.count;
      match = valid && (entry_ff.key_high == new_entry.key_high)
                    && (entry_ff.key_low == new_entry.key_low);
      sel_in = sel_ff;
      if (ctl.capture) begin
         sel_in = (ctl.use_key && match) || (ctl.use_index && valid && (HERE == ctl.index));
      end

      entry_in = entry_ff;
      if (ctl.apply) begin
         priority if (ctl.put && (HERE == ctl.put_at)) begin
            entry_in = new_entry;
         end else if (ctl.up && (HERE != '0) && (HERE <= ctl.hi)) begin
            entry_in = left_entry;
         end else if (ctl.dn && (HERE >= ctl.lo) && (HERE < ctl.hi)) begin
            entry_in = right_entry;
         end else begin
            entry_in = entry_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         sel_ff <= 1'b0;
      end else begin
         sel_ff <= sel_in;
      end
   end

   assign entry = entry_ff;
   assign sel   = sel_ff;

endmodule

FILE: hdl/rlmf_select.sv
`timescale 1ns / 1ps

module rlmf_select #(
   parameter int CAPACITY = rlmf_pkg::CAPACITY_DEF,
   parameter int IDX_W    = $clog2(CAPACITY)
) (
   input  logic                [CAPACITY-1:0] sel,
   input  rlmf_pkg::entry_type entries [CAPACITY],
   output logic                               any,
   output logic                [IDX_W-1:0]    pos,
   output rlmf_pkg::entry_type                data
);

   // at most one cell is selected, so an AND-OR reduction acts as the mux
   always_comb begin
      any  = |sel;
      pos  = '0;
      data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (sel[i]) begin
            pos  = pos | IDX_W'(i);
            data = data | entries[i];
         end
      end
   end

endmodule

FILE: hdl/recent_list_move_to_front.sv
`timescale 1ns / 1ps
// A transaction passes through match capture, reduction, then the chain shift with the
// response register; that last step waits while a held response is stalled.
// The single-item sequencer takes a new transaction only after the last has been applied.
// Reset: synchronous, active high; clears the entry count, sequencer and response
// valid. Cell contents are not cleared; entries at or above the count are never read.
module recent_list_move_to_front #(
   parameter int CAPACITY     = rlmf_pkg::CAPACITY_DEF,
   parameter int PAYLOAD_BITS = rlmf_pkg::PAYLOAD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [rlmf_pkg::OP_W-1:0]       req_opcode,
   input  logic [rlmf_pkg::KEY_HI_W-1:0]   req_key_high,
   input  logic [rlmf_pkg::KEY_LO_W-1:0]   req_key_low,
   input  logic [rlmf_pkg::PL_W-1:0]       req_payload,
   input  logic [rlmf_pkg::POS_W-1:0]      req_index,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rlmf_pkg::STAT_W-1:0]     rsp_status,
   output logic                            rsp_hit,
   output logic [rlmf_pkg::POS_W-1:0]      rsp_position,
   output logic [rlmf_pkg::TOTAL_W-1:0]    rsp_entry_total,
   output logic                            rsp_evicted,
   output logic [rlmf_pkg::KEY_HI_W-1:0]   rsp_out_key_high,
   output logic [rlmf_pkg::KEY_LO_W-1:0]   rsp_out_key_low,
   output logic [rlmf_pkg::PL_W-1:0]       rsp_out_payload
);

   localparam int IDX_W   = $clog2(CAPACITY);
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int POS_W   = rlmf_pkg::POS_W;
   localparam int TOTAL_W = rlmf_pkg::TOTAL_W;
   localparam int PL_KEEP = (PAYLOAD_BITS < rlmf_pkg::PL_W) ? PAYLOAD_BITS : rlmf_pkg::PL_W;
   localparam logic [rlmf_pkg::PL_W-1:0] PL_MASK =
      rlmf_pkg::PL_W'((65'd1 << PL_KEEP) - 65'd1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_MATCH   = 4'b0010,
      ST_RESOLVE = 4'b0100,
      ST_APPLY   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [rlmf_pkg::OP_W-1:0]  op_ff;
   logic [POS_W-1:0]           idx_ff;
   rlmf_pkg::entry_type        req_entry_ff;
   logic [CNT_W-1:0]           count_ff, count_in;

   logic                       found_ff;
   logic [IDX_W-1:0]           pos_ff;
   rlmf_pkg::entry_type        rdata_ff;

   logic                       rsp_valid_ff;
   logic [rlmf_pkg::STAT_W-1:0] rsp_status_ff, status_in;
   logic                       rsp_hit_ff, hit_in;
   logic [POS_W-1:0]           rsp_position_ff, position_in;
   logic [TOTAL_W-1:0]         rsp_entry_total_ff;
   logic                       rsp_evicted_ff, evicted_in;
   rlmf_pkg::entry_type        rsp_data_ff, data_in;

   rlmf_pkg::cell_ctl_type     ctl;
   rlmf_pkg::entry_type        cell_entry [CAPACITY];
   logic [CAPACITY-1:0]        cell_sel;

   logic                       sel_any;
   logic [IDX_W-1:0]           sel_pos;
   rlmf_pkg::entry_type        sel_data;

   logic                       accept;
   logic                       fire;
   logic                       key_op;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign fire      = (state_ff == ST_APPLY) && !(rsp_valid_ff && rsp_stall);
   assign key_op    = (op_ff <= rlmf_pkg::OP_APPEND);

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         rlmf_pkg::entry_type left_entry, right_entry;
         if (gi == 0) begin : g_first
            assign left_entry = req_entry_ff;
         end else begin : g_left
            assign left_entry = cell_entry[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_last
            assign right_entry = cell_entry[gi];
         end else begin : g_right
            assign right_entry = cell_entry[gi+1];
         end
         rlmf_cell #(
            .CELL_INDEX (gi)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .new_entry   (req_entry_ff),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (cell_entry[gi]),
            .sel         (cell_sel[gi])
         );
      end
   endgenerate

   rlmf_select #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W)
   ) u_select (
      .sel     (cell_sel),
      .entries (cell_entry),
      .any     (sel_any),
      .pos     (sel_pos),
      .data    (sel_data)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (accept) state_in = ST_MATCH;
         ST_MATCH:   state_in = ST_RESOLVE;
         ST_RESOLVE: state_in = ST_APPLY;
         ST_APPLY:   if (fire) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl           = '0;
      ctl.capture   = (state_ff == ST_MATCH);
      ctl.use_key   = key_op;
      ctl.use_index = (op_ff == rlmf_pkg::OP_READ);
      ctl.count     = POS_W'(count_ff);
      ctl.index     = idx_ff;
      ctl.apply     = fire;

      count_in    = count_ff;
      status_in   = rlmf_pkg::STAT_OK;
      evicted_in  = 1'b0;
      hit_in      = key_op && found_ff;
      position_in = (key_op && found_ff) ? POS_W'(pos_ff) : '0;
      data_in     = '0;

      unique case (op_ff)
         rlmf_pkg::OP_ADD: begin
            ctl.up     = 1'b1;
            ctl.put    = 1'b1;
            ctl.put_at = '0;
            if (found_ff) begin
               ctl.hi = POS_W'(pos_ff);
            end else if (count_ff < CAP_CNT) begin
               ctl.hi   = POS_W'(count_ff);
               count_in = count_ff + CNT_W'(1);
            end else begin
               ctl.hi     = POS_W'(CAPACITY - 1);
               evicted_in = 1'b1;
            end
         end
         rlmf_pkg::OP_REMOVE: begin
            if (found_ff) begin
               ctl.dn   = 1'b1;
               ctl.lo   = POS_W'(pos_ff);
               ctl.hi   = POS_W'(count_ff - CNT_W'(1));
               count_in = count_ff - CNT_W'(1);
            end else begin
               status_in = rlmf_pkg::STAT_NOT_FOUND;
            end
         end
         rlmf_pkg::OP_LOOKUP: begin
            if (found_ff) begin
               data_in = rdata_ff;
            end else begin
               status_in = rlmf_pkg::STAT_NOT_FOUND;
            end
         end
         rlmf_pkg::OP_APPEND: begin
            if (count_ff >= CAP_CNT) begin
               status_in = rlmf_pkg::STAT_FULL;
            end else if (found_ff) begin
               status_in = rlmf_pkg::STAT_DUPLICATE;
            end else begin
               ctl.put    = 1'b1;
               ctl.put_at = POS_W'(count_ff);
               count_in   = count_ff + CNT_W'(1);
            end
         end
         rlmf_pkg::OP_READ: begin
            if (found_ff) begin
               data_in = rdata_ff;
            end else begin
               status_in = rlmf_pkg::STAT_BAD_INDEX;
            end
         end
         rlmf_pkg::OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff                 <= req_opcode;
         idx_ff                <= req_index;
         req_entry_ff.key_high <= req_key_high;
         req_entry_ff.key_low  <= req_key_low;
         req_entry_ff.payload  <= req_payload & PL_MASK;
      end
      if (state_ff == ST_RESOLVE) begin
         found_ff <= sel_any;
         pos_ff   <= sel_pos;
         rdata_ff <= sel_data;
      end
      if (fire) begin
         rsp_status_ff      <= status_in;
         rsp_hit_ff         <= hit_in;
         rsp_position_ff    <= position_in;
         rsp_entry_total_ff <= TOTAL_W'(count_in);
         rsp_evicted_ff     <= evicted_in;
         rsp_data_ff        <= data_in;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (fire) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_position     = rsp_position_ff;
   assign rsp_entry_total  = rsp_entry_total_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_out_key_high = rsp_data_ff.key_high;
   assign rsp_out_key_low  = rsp_data_ff.key_low;
   assign rsp_out_payload  = rsp_data_ff.payload;

endmodule

FILE: verif/recent_list_checker.sv
`timescale 1ns / 1ps

module recent_list_checker
   import rlmf_pkg::*;
#(
   parameter int CAPACITY     = CAPACITY_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [OP_W-1:0]     req_opcode,
   input  logic [KEY_HI_W-1:0] req_key_high,
   input  logic [KEY_LO_W-1:0] req_key_low,
   input  logic [PL_W-1:0]     req_payload,
   input  logic [POS_W-1:0]    req_index,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [STAT_W-1:0]   rsp_status,
   input  logic                rsp_hit,
   input  logic [POS_W-1:0]    rsp_position,
   input  logic [TOTAL_W-1:0]  rsp_entry_total,
   input  logic                rsp_evicted,
   input  logic [KEY_HI_W-1:0] rsp_out_key_high,
   input  logic [KEY_LO_W-1:0] rsp_out_key_low,
   input  logic [PL_W-1:0]     rsp_out_payload,
   output int                  failures,
   output int                  outstanding,
   output int                  checked
);

   typedef struct packed {
      logic [STAT_W-1:0]   status;
      logic                hit;
      logic [POS_W-1:0]    position;
      logic [TOTAL_W-1:0]  entry_total;
      logic                evicted;
      logic [KEY_HI_W-1:0] key_high;
      logic [KEY_LO_W-1:0] key_low;
      logic [PL_W-1:0]     payload;
   } list_rsp_type;

   logic [KEY_HI_W-1:0] list_key_high [CAPACITY];
   logic [KEY_LO_W-1:0] list_key_low  [CAPACITY];
   logic [PL_W-1:0]     list_payload  [CAPACITY];
   int                  list_count;

   list_rsp_type predicted_responses [$];
   list_rsp_type exp_rsp;
   list_rsp_type act_rsp;

   function automatic logic [PL_W-1:0] payload_mask();
      logic [PL_W-1:0] m;
      m = '0;
      for (int b = 0; b < PL_W; b++)
         if (b < PAYLOAD_BITS)
            m[b] = 1'b1;
      return m;
   endfunction

   function automatic void shift_entries_up(int n);
      for (int i = n; i > 0; i--) begin
         if (i < CAPACITY) begin
            list_key_high[i] = list_key_high[i-1];
            list_key_low[i]  = list_key_low[i-1];
            list_payload[i]  = list_payload[i-1];
         end
      end
   endfunction

   function automatic list_rsp_type predict_list_op(
      logic [OP_W-1:0]     op,
      logic [KEY_HI_W-1:0] kh,
      logic [KEY_LO_W-1:0] kl,
      logic [PL_W-1:0]     pl_in,
      logic [POS_W-1:0]    idx
   );
      list_rsp_type    r;
      int              found;
      logic [PL_W-1:0] pl;
      r     = '0;
      found = -1;
      pl    = pl_in & payload_mask();
      if (op <= OP_APPEND) begin
         for (int i = 0; i < list_count && i < CAPACITY; i++)
            if (found < 0 && list_key_high[i] == kh && list_key_low[i] == kl)
               found = i;
         if (found >= 0) begin
            r.hit      = 1'b1;
            r.position = found[POS_W-1:0];
         end
      end
      case (op)
         OP_ADD: begin
            if (found >= 0) begin
               shift_entries_up(found);
            end else if (list_count < CAPACITY) begin
               shift_entries_up(list_count);
               list_count++;
            end else begin
               shift_entries_up(CAPACITY - 1);
               r.evicted = 1'b1;
            end
            list_key_high[0] = kh;
            list_key_low[0]  = kl;
            list_payload[0]  = pl;
         end
         OP_REMOVE: begin
            if (found < 0) begin
               r.status = STAT_NOT_FOUND;
            end else begin
               for (int i = found; i + 1 < list_count && i + 1 < CAPACITY; i++) begin
                  list_key_high[i] = list_key_high[i+1];
                  list_key_low[i]  = list_key_low[i+1];
                  list_payload[i]  = list_payload[i+1];
               end
               list_count--;
            end
         end
         OP_LOOKUP: begin
            if (found < 0) begin
               r.status = STAT_NOT_FOUND;
            end else begin
               r.key_high = list_key_high[found];
               r.key_low  = list_key_low[found];
               r.payload  = list_payload[found];
            end
         end
         OP_APPEND: begin
            if (list_count >= CAPACITY) begin
               r.status = STAT_FULL;
            end else if (found >= 0) begin
               r.status = STAT_DUPLICATE;
            end else begin
               list_key_high[list_count] = kh;
               list_key_low[list_count]  = kl;
               list_payload[list_count]  = pl;
               list_count++;
            end
         end
         OP_READ: begin
            if (idx < list_count && idx < CAPACITY) begin
               r.key_high = list_key_high[idx];
               r.key_low  = list_key_low[idx];
               r.payload  = list_payload[idx];
            end else begin
               r.status = STAT_BAD_INDEX;
            end
         end
         OP_CLEAR: begin
            list_count = 0;
         end
         default: begin
         end
      endcase
      r.entry_total = list_count[TOTAL_W-1:0];
      return r;
   endfunction

   task automatic check_field(string name, logic [63:0] expected, logic [63:0] actual);
      if (expected !== actual) begin
         $error("%s: expected %0h, actual %0h", name, expected, actual);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         list_count = 0;
         predicted_responses.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            act_rsp = '{rsp_status, rsp_hit, rsp_position, rsp_entry_total, rsp_evicted,
                        rsp_out_key_high, rsp_out_key_low, rsp_out_payload};
            if (predicted_responses.size() == 0) begin
               $error("response transaction with none expected");
               failures++;
            end else begin
               exp_rsp = predicted_responses.pop_front();
               check_field("status", 64'(exp_rsp.status), 64'(act_rsp.status));
               check_field("hit", 64'(exp_rsp.hit), 64'(act_rsp.hit));
               check_field("position", 64'(exp_rsp.position), 64'(act_rsp.position));
               check_field("entry_total", 64'(exp_rsp.entry_total),
                           64'(act_rsp.entry_total));
               check_field("evicted", 64'(exp_rsp.evicted), 64'(act_rsp.evicted));
               check_field("out_key_high", 64'(exp_rsp.key_high), 64'(act_rsp.key_high));
               check_field("out_key_low", exp_rsp.key_low, act_rsp.key_low);
               check_field("out_payload", 64'(exp_rsp.payload), 64'(act_rsp.payload));
               checked++;
            end
         end
         if (req_valid && !req_stall)
            predicted_responses.push_back(
               predict_list_op(req_opcode, req_key_high, req_key_low, req_payload, req_index));
      end
      outstanding <= predicted_responses.size();
   end

endmodule

FILE: verif/recent_list_move_to_front_test.sv
`timescale 1ns / 1ps

module recent_list_move_to_front_test;
   import rlmf_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
   localparam int KEY_POOL_SIZE = 48;
   localparam int PHASE_ITEMS   = 416;

   logic                clock;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_opcode       = '0;
   logic [KEY_HI_W-1:0] req_key_high     = '0;
   logic [KEY_LO_W-1:0] req_key_low      = '0;
   logic [PL_W-1:0]     req_payload      = '0;
   logic [POS_W-1:0]    req_index        = '0;
   logic                rsp_valid;
   logic                rsp_stall        = 1'b0;
   logic [STAT_W-1:0]   rsp_status;
   logic                rsp_hit;
   logic [POS_W-1:0]    rsp_position;
   logic [TOTAL_W-1:0]  rsp_entry_total;
   logic                rsp_evicted;
   logic [KEY_HI_W-1:0] rsp_out_key_high;
   logic [KEY_LO_W-1:0] rsp_out_key_low;
   logic [PL_W-1:0]     rsp_out_payload;

   int failures;
   int outstanding;
   int checked;
   int req_idle_pct  = 25;
   int rsp_stall_pct = 56;
   int op_sent [8];

   logic [KEY_HI_W-1:0] pool_key_high [KEY_POOL_SIZE];
   logic [KEY_LO_W-1:0] pool_key_low  [KEY_POOL_SIZE];

   recent_list_move_to_front dut (.*);

   recent_list_checker list_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   always @(posedge clock)
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);

   task automatic send_request(
      logic [OP_W-1:0]     op,
      logic [KEY_HI_W-1:0] kh,
      logic [KEY_LO_W-1:0] kl,
      logic [PL_W-1:0]     pl,
      logic [POS_W-1:0]    idx
   );
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_key_high <= kh;
      req_key_low  <= kl;
      req_payload  <= pl;
      req_index    <= idx;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      op_sent[op]++;
   endtask

   task automatic send_random_request();
      int                  r;
      int                  k;
      logic [OP_W-1:0]     op;
      logic [KEY_HI_W-1:0] kh;
      logic [KEY_LO_W-1:0] kl;
      logic [POS_W-1:0]    idx;
      r = $urandom_range(0, 99);
      if (r < 30)
         op = OP_ADD;
      else if (r < 42)
         op = OP_REMOVE;
      else if (r < 56)
         op = OP_LOOKUP;
      else if (r < 78)
         op = OP_APPEND;
      else if (r < 94)
         op = OP_READ;
      else if (r < 99)
         op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
      else
         op = OP_CLEAR;
      if ($urandom_range(0, 99) < 85) begin
         k  = $urandom_range(0, KEY_POOL_SIZE - 1);
         kh = pool_key_high[k];
         kl = pool_key_low[k];
      end else begin
         kh = KEY_HI_W'($urandom);
         kl = {$urandom, $urandom};
      end
      idx = ($urandom_range(0, 9) < 7) ? POS_W'($urandom_range(0, 33))
                                       : POS_W'($urandom_range(0, 63));
      send_request(op, kh, kl, $urandom, idx);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   initial begin
      logic [KEY_HI_W-1:0] hi_ones;
      logic [KEY_LO_W-1:0] lo_ones;
      hi_ones = '1;
      lo_ones = '1;
      for (int k = 0; k < KEY_POOL_SIZE; k++) begin
         pool_key_high[k] = KEY_HI_W'($urandom);
         pool_key_low[k]  = {$urandom, $urandom};
         if (k % 4 == 1) begin
            pool_key_low[k]  = pool_key_low[k-1];
            pool_key_high[k] = pool_key_high[k-1] ^ (24'd1 << $urandom_range(0, 23));
         end else if (k % 4 == 3) begin
            pool_key_high[k] = pool_key_high[k-1];
            pool_key_low[k]  = pool_key_low[k-1] ^ (64'd1 << $urandom_range(0, 63));
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty list, near-miss keys, move to front, spare opcodes
      send_request(OP_CLEAR,  '0,      '0,      '0,      '0);
      send_request(OP_READ,   '0,      '0,      '0,      '0);
      send_request(OP_LOOKUP, '0,      '0,      '0,      '0);
      send_request(OP_REMOVE, '0,      '0,      '0,      '0);
      send_request(OP_APPEND, '0,      '0,      '0,      '0);
      send_request(OP_ADD,    hi_ones, lo_ones, '1,      '1);
      send_request(OP_ADD,    hi_ones, '0,      32'h5a5a_a5a5, '0);
      send_request(OP_APPEND, '0,      '0,      '1,      '0);
      send_request(OP_LOOKUP, '0,      '0,      '0,      '0);
      send_request(OP_ADD,    '0,      '0,      32'hdead_beef, '0);
      send_request(OP_READ,   '0,      '0,      '0,      6'd0);
      send_request(OP_READ,   '0,      '0,      '0,      6'd2);
      send_request(OP_READ,   '0,      '0,      '0,      6'd3);
      send_request(OP_READ,   '0,      '0,      '0,      '1);
      send_request(OP_APPEND, '0,      lo_ones, 32'h1234_5678, '0);
      send_request(OP_REMOVE, hi_ones, lo_ones, '0,      '0);
      send_request(OP_LOOKUP, hi_ones, lo_ones, '0,      '0);
      send_request(OP_SPARE_LO, hi_ones, lo_ones, '1,    '1);
      send_request(OP_SPARE_HI, '0,    '0,      '0,      '0);
      send_request(OP_REMOVE, '0,      '0,      '0,      '0);
      send_request(OP_LOOKUP, '0,      lo_ones, '0,      '0);
      send_request(OP_CLEAR,  hi_ones, lo_ones, '1,      '1);
      send_request(OP_READ,   '0,      '0,      '0,      '0);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct  = 25;
               rsp_stall_pct = 56;
            end
            1: begin
               req_idle_pct  = 56;
               rsp_stall_pct = 25;
            end
            default: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_random_request();
         // hold off until the list has answered everything
         wait_for_drain();
      end

      repeat (12) @(posedge clock);

      $display("Run covered %0d checked responses over three idle/stall mixes:", checked);
      $display("  add %0d, remove %0d, lookup %0d, append %0d, read %0d, clear %0d, spare %0d",
               op_sent[OP_ADD], op_sent[OP_REMOVE], op_sent[OP_LOOKUP], op_sent[OP_APPEND],
               op_sent[OP_READ], op_sent[OP_CLEAR], op_sent[OP_SPARE_LO] + op_sent[OP_SPARE_HI]);
      if (failures == 0 && outstanding == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
